[rtl/core/drr_pkg.sv]
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types and constants for the deficit round robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QUANTA  = 4;

	localparam int CLS_W   = 2;
	localparam int LEN_W   = 16;
	localparam int DEF_W   = 17;
	localparam int CNT_W   = 3;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = $clog2(NUM_CLASSES * QUEUE_DEPTH);
	localparam int PADDR_W = 4;

	localparam logic [DEF_W-1:0] DEFICIT_MAX   = {DEF_W{1'b1}};
	localparam logic [LEN_W-1:0] QUANTUM_RESET = LEN_W'(1500);

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_SENT     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic             operation;
		logic [CLS_W-1:0] class_index;
		logic [LEN_W-1:0] packet_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CLS_W-1:0] sent_class;
		logic [LEN_W-1:0] sent_length;
	} out_item_t;

	// Queued command, classified by the front part.
	typedef struct packed {
		logic             operation;
		logic             class_ok;
		logic [CLS_W-1:0] class_index;
		logic [LEN_W-1:0] packet_length;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_q_t;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLS_W-1:0] cls,
			input logic [PTR_W-1:0] slot);
		mem_addr = ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
	endfunction

	// (a + b) mod NUM_CLASSES where a < NUM_CLASSES and b <= NUM_CLASSES
	function automatic logic [CLS_W-1:0] ring_wrap(input logic [CLS_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(NUM_CLASSES)) s = s - (CNT_W+1)'(NUM_CLASSES);
		ring_wrap = s[CLS_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/deficit_round_robin_scheduler.sv]
// ----------------------------------------------------------------------------
// deficit_round_robin_scheduler
// Deficit round robin over four per-class packet-length FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item (operation, class_index, packet_length) is
//    taken on a rising edge with start high and busy low. busy rises only
//    when the two-entry command queue is full.
//  - Result channel: one result per item, shown for one cycle with done
//    high. The receiver cannot stall; results leave in command order.
//  - Enqueue: the result is registered when the item leaves the command
//    queue. Full FIFO or class out of range is rejected and changes nothing.
//  - Dequeue: each ring visit until a class's deficit covers its head
//    packet passes a credit state (with the length memory read) and a
//    compare state; this loop sets the rate. An empty ring answers
//    straight from the idle state.
//  - APB port: four 16-bit quantum registers at 0x0, 0x4, 0x8, 0xC, reset
//    1500; a quantum of zero acts as one. Write only while idle.
//  - Reset (arst_n low): queues empty, ring empty, deficits zero. The
//    length memory needs no clearing; entries are read only once written.
// ----------------------------------------------------------------------------
`default_nettype none

module deficit_round_robin_scheduler import drr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire in_item_t           cmd,
	output logic                    busy,
	output logic                    done,
	output out_item_t               result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [NUM_QUANTA-1:0][LEN_W-1:0] quantum_q;
	cmd_q_t                           head;
	logic                             pop;
	logic [1:0]                       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign prdata  = {16'd0, quantum_q[reg_idx]};

	// quantum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUANTA; i++) quantum_q[i] <= QUANTUM_RESET;
		end else if (psel && penable && pwrite) begin
			quantum_q[reg_idx] <= pwdata[LEN_W-1:0];
		end
	end

	// front: accept and classify
	drr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.head   (head),
		.pop    (pop)
	);

	// back: FIFOs, ring and deficit service
	drr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.quantum (quantum_q),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

[rtl/core/drr_front.sv]
// ----------------------------------------------------------------------------
// drr_front
// Accepts items, checks the class range and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_front import drr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire in_item_t cmd,
	output logic          busy,
	output cmd_q_t        head,
	input  wire logic     pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cmd_in;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;

	always_comb begin
		cmd_in.operation     = cmd.operation;
		cmd_in.class_ok      = (32'(cmd.class_index) < NUM_CLASSES);
		cmd_in.class_index   = cmd.class_index;
		cmd_in.packet_length = cmd.packet_length;
	end

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

[rtl/core/drr_back.sv]
// ----------------------------------------------------------------------------
// drr_back
// Executes queued commands: FIFO stores, active ring and deficit service.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_back import drr_pkg::*; (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cmd_q_t                             head,
	output logic                                    pop,
	input  wire logic [NUM_QUANTA-1:0][LEN_W-1:0]   quantum,
	output logic                                    done,
	output out_item_t                               result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CRED = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;

	logic [1:0]        state_q;
	logic [DEF_W-1:0]  deficit_q [NUM_CLASSES];
	logic [CLS_W-1:0]  ring_q [NUM_CLASSES];
	logic [CLS_W-1:0]  ring_head_q;
	logic [CNT_W-1:0]  ring_count_q;
	logic [NUM_CLASSES-1:0] mask_q;
	logic              credited_q;
	logic [PTR_W-1:0]  rd_ptr_q [NUM_CLASSES];
	logic [FILL_W-1:0] fill_q [NUM_CLASSES];
	logic [CLS_W-1:0]  cls_q;
	logic [LEN_W-1:0]  mem [NUM_CLASSES * QUEUE_DEPTH];
	logic [LEN_W-1:0]  rdata_q;

	cmd_t              c;
	logic [CLS_W-1:0]  ring_cls;
	logic [LEN_W-1:0]  q_eff;
	logic [DEF_W:0]    def_sum;
	logic [PTR_W:0]    slot_sum;
	logic [PTR_W-1:0]  wr_slot;
	logic              fifo_full;
	logic [CLS_W-1:0]  tail;
	logic              covered;
	logic              done_d;
	out_item_t         result_d;

	assign c        = head.cmd;
	assign pop      = (state_q == S_IDLE) && head.valid;
	assign ring_cls = ring_q[ring_head_q];
	assign tail     = ring_wrap(ring_head_q, ring_count_q);
	assign covered  = (DEF_W'(rdata_q) <= deficit_q[cls_q]);

	always_comb begin
		q_eff   = (quantum[ring_cls] == '0) ? LEN_W'(1) : quantum[ring_cls];
		def_sum = (DEF_W+1)'(deficit_q[ring_cls]) + (DEF_W+1)'(q_eff);
		fifo_full = (fill_q[c.class_index] == FILL_W'(QUEUE_DEPTH));
		slot_sum  = (PTR_W+1)'(rd_ptr_q[c.class_index])
			+ (PTR_W+1)'(fill_q[c.class_index]);
		if (slot_sum >= (PTR_W+1)'(QUEUE_DEPTH))
			slot_sum = slot_sum - (PTR_W+1)'(QUEUE_DEPTH);
		wr_slot = slot_sum[PTR_W-1:0];
	end

	// next result
	always_comb begin
		done_d   = 1'b0;
		result_d = '0;
		case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					if (c.operation == OP_ENQUEUE) begin
						done_d          = 1'b1;
						result_d.status = (!c.class_ok || fifo_full) ? ST_REJECTED
							: ST_ENQUEUED;
					end else if (ring_count_q == '0) begin
						done_d          = 1'b1;
						result_d.status = ST_EMPTY;
					end
				end
			end
			S_CMP: begin
				if (covered) begin
					done_d               = 1'b1;
					result_d.status      = ST_SENT;
					result_d.sent_class  = cls_q;
					result_d.sent_length = rdata_q;
				end
			end
			default: ;
		endcase
	end

	// length store, registered read
	always_ff @(posedge clk) begin
		if (pop && c.operation == OP_ENQUEUE && c.class_ok && !fifo_full)
			mem[mem_addr(c.class_index, wr_slot)] <= c.packet_length;
		rdata_q <= mem[mem_addr(ring_cls, rd_ptr_q[ring_cls])];
	end

	// ring entries: written at the tail only
	always_ff @(posedge clk) begin
		if (pop && c.operation == OP_ENQUEUE && c.class_ok && !fifo_full
				&& !mask_q[c.class_index])
			ring_q[tail] <= c.class_index;
		else if (state_q == S_CMP && !covered)
			ring_q[tail] <= cls_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ring_head_q  <= '0;
			ring_count_q <= '0;
			mask_q       <= '0;
			credited_q   <= 1'b0;
			cls_q        <= '0;
			done         <= 1'b0;
			result       <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				deficit_q[i] <= '0;
				rd_ptr_q[i]  <= '0;
				fill_q[i]    <= '0;
			end
		end else begin
			done   <= done_d;
			result <= result_d;
			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						if (c.operation == OP_ENQUEUE) begin
							if (c.class_ok && !fifo_full) begin
								fill_q[c.class_index] <= fill_q[c.class_index] + 1'b1;
								if (!mask_q[c.class_index]) begin
									deficit_q[c.class_index] <= '0;
									mask_q[c.class_index]    <= 1'b1;
									ring_count_q             <= ring_count_q + 1'b1;
								end
							end
						end else if (ring_count_q != '0) begin
							state_q <= S_CRED;
						end
					end
				end
				S_CRED: begin
					// credit once per visit, memory read is issued this cycle
					cls_q <= ring_cls;
					if (!credited_q) begin
						deficit_q[ring_cls] <= def_sum[DEF_W] ? DEFICIT_MAX
							: def_sum[DEF_W-1:0];
						credited_q <= 1'b1;
					end
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!covered) begin
						// not covered: class goes to the back
						ring_head_q <= ring_wrap(ring_head_q, CNT_W'(1));
						credited_q  <= 1'b0;
						state_q     <= S_CRED;
					end else begin
						// a draining class leaves the ring with no credit kept
						deficit_q[cls_q]   <= (fill_q[cls_q] == FILL_W'(1)) ? '0
							: deficit_q[cls_q] - DEF_W'(rdata_q);
						rd_ptr_q[cls_q]    <= (rd_ptr_q[cls_q] == PTR_W'(QUEUE_DEPTH - 1))
							? '0 : rd_ptr_q[cls_q] + 1'b1;
						fill_q[cls_q]      <= fill_q[cls_q] - 1'b1;
						if (fill_q[cls_q] == FILL_W'(1)) begin
							ring_head_q      <= ring_wrap(ring_head_q, CNT_W'(1));
							ring_count_q     <= ring_count_q - 1'b1;
							mask_q[cls_q]    <= 1'b0;
							credited_q       <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
